// File: hw/rtl/ghh_pkg.sv
package ghh_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned PEAK_W    = 24;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned SEL_W     = 3;
    localparam int unsigned BIN_IN_W  = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIG_BIN_WIDTH  = 3'd0,
        REG_EVENT_BIN_WIDTH = 3'd1,
        REG_TRIG_WIN_LOW    = 3'd2,
        REG_TRIG_WIN_HIGH   = 3'd3,
        REG_EVENT_WIN_LOW   = 3'd4,
        REG_EVENT_WIN_HIGH  = 3'd5,
        REG_PEAK_WIN_LOW    = 3'd6,
        REG_PEAK_WIN_HIGH   = 3'd7
    } reg_idx_t;

    typedef enum logic [0:0] {
        CMD_RECORD = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_WAIT,
        ST_WR,
        ST_RDOUT,
        ST_RDWAIT,
        ST_OUT
    } state_t;

endpackage

// File: hw/rtl/gated_hit_histogrammer_top.sv
// Gated multi-parameter hit histogram. A record request (cmd 0) bins the trigger time,
// event time and peak value as ceil(value / width) and bumps three total bins, plus three
// gated bins when every value lies strictly inside its window; counts saturate at
// 2^32-1, and a bin index past NUM_BINS-1 saturates and sets the sticky overflow flag.
// A read request (cmd 1) returns one count. A record keeps the input busy while one
// shared restoring divider takes each value in turn (load, 32 quotient bits, bin store),
// then each of the three bins takes a read-modify-write (states RD, WAIT, WR) through
// the registered-read count memories. A read passes through RDOUT and RDWAIT before its
// result shows in OUT, and the input is ready again in the cycle after the result is
// taken. After reset a clearing pass over all 3*NUM_BINS addresses zeroes the memories
// before the first request is accepted.
module gated_hit_histogrammer_top
    import ghh_pkg::*;
#(
    parameter int unsigned NUM_BINS       = 1024,
    parameter int unsigned PEAK_BIN_WIDTH = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [STAMP_W-1:0]   s_trig_stamp,
    input  logic [STAMP_W-1:0]   s_event_stamp,
    input  logic [PEAK_W-1:0]    s_peak_value,
    input  logic [SEL_W-1:0]     s_hist_select,
    input  logic [BIN_IN_W-1:0]  s_bin_number,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COUNT_W-1:0]   m_bin_count,
    output logic                 m_overflow_seen
);

    localparam int unsigned BIN_W   = $clog2(NUM_BINS);
    localparam int unsigned DEPTH   = 3 * NUM_BINS;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [5:0] STEP_STORE = 6'd33;

    // configuration
    logic [31:0]       trig_w_reg, event_w_reg, tlo_reg, thi_reg, elo_reg, ehi_reg;
    logic [PEAK_W-1:0] plo_reg, phi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_w_reg  <= 32'd5;
            event_w_reg <= 32'd500;
            tlo_reg     <= 32'd0;
            thi_reg     <= 32'd100000;
            elo_reg     <= 32'd0;
            ehi_reg     <= 32'd1000000;
            plo_reg     <= '0;
            phi_reg     <= PEAK_W'(10000);
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_TRIG_BIN_WIDTH:  trig_w_reg  <= cfg_data;
                REG_EVENT_BIN_WIDTH: event_w_reg <= cfg_data;
                REG_TRIG_WIN_LOW:    tlo_reg     <= cfg_data;
                REG_TRIG_WIN_HIGH:   thi_reg     <= cfg_data;
                REG_EVENT_WIN_LOW:   elo_reg     <= cfg_data;
                REG_EVENT_WIN_HIGH:  ehi_reg     <= cfg_data;
                REG_PEAK_WIN_LOW:    plo_reg     <= cfg_data[PEAK_W-1:0];
                REG_PEAK_WIN_HIGH:   phi_reg     <= cfg_data[PEAK_W-1:0];
                default: ;
            endcase
        end
    end

    // memories
    logic [COUNT_W-1:0] total_mem [DEPTH];
    logic [COUNT_W-1:0] gated_mem [DEPTH];
    logic [COUNT_W-1:0] total_q_reg, gated_q_reg;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic               wr_total, wr_gated;
    logic [COUNT_W-1:0] wr_total_data, wr_gated_data;

    always_ff @(posedge aclk) begin
        if (wr_total) total_mem[wr_addr] <= wr_total_data;
        if (wr_gated) gated_mem[wr_addr] <= wr_gated_data;
        total_q_reg <= total_mem[rd_addr];
        gated_q_reg <= gated_mem[rd_addr];
    end

    // control state
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg;
    logic [1:0]         val_reg;      // which value: 0 trig, 1 event, 2 peak
    logic [5:0]         step_reg;     // divider step count
    logic [STAMP_W-1:0] quo_reg;
    logic [STAMP_W:0]   rem_reg;
    logic [STAMP_W-1:0] dvd_reg, dvs_reg;
    logic               zero_reg, wz_reg;
    logic [BIN_W-1:0]   bins_reg [3];
    logic               gate_reg, ovf_reg;
    logic [STAMP_W-1:0] trig_reg, event_reg;
    logic [PEAK_W-1:0]  peak_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic [BIN_IN_W-1:0] binno_reg;
    logic [COUNT_W-1:0] out_reg;

    logic accept;
    assign accept = s_valid && s_ready;

    // divider operand selection
    logic [STAMP_W-1:0] cur_val, cur_w;
    always_comb begin
        unique case (val_reg)
            2'd0:    begin cur_val = trig_reg;  cur_w = trig_w_reg; end
            2'd1:    begin cur_val = event_reg; cur_w = event_w_reg; end
            default: begin cur_val = STAMP_W'(peak_reg); cur_w = STAMP_W'(PEAK_BIN_WIDTH); end
        endcase
    end

    // shifted remainder can reach 33 bits, so decide by compare, not by the borrow
    logic [STAMP_W:0] rem_shift, rem_sub;
    logic             rem_ge;
    assign rem_shift = {rem_reg[STAMP_W-1:0], dvd_reg[STAMP_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign rem_ge    = (rem_shift >= {1'b0, dvs_reg});

    // bin from finished quotient: (v-1)/w + 1, saturated
    logic [STAMP_W:0] q_plus;
    logic [BIN_W-1:0] bin_fin;
    logic             bin_ovf;
    always_comb begin
        q_plus  = {1'b0, quo_reg} + 1'b1;
        bin_ovf = 1'b0;
        if (zero_reg) begin
            bin_fin = '0;
        end else if (wz_reg || q_plus > (STAMP_W+1)'(NUM_BINS - 1)) begin
            bin_fin = LAST_BIN;
            bin_ovf = 1'b1;
        end else begin
            bin_fin = q_plus[BIN_W-1:0];
        end
    end

    logic [ADDR_W-1:0] rmw_addr;
    assign rmw_addr = ADDR_W'(val_reg) * ADDR_W'(NUM_BINS) + ADDR_W'(bins_reg[val_reg]);

    logic [ADDR_W-1:0] rd_sel_addr;
    assign rd_sel_addr = (sel_reg < SEL_W'(3)) ?
        ADDR_W'(sel_reg[1:0]) * ADDR_W'(NUM_BINS) + ADDR_W'(binno_reg) :
        ADDR_W'(sel_reg - SEL_W'(3)) * ADDR_W'(NUM_BINS) + ADDR_W'(binno_reg);

    logic read_ok;
    assign read_ok = ({{(32-BIN_IN_W){1'b0}}, binno_reg} < 32'(NUM_BINS))
                     && (sel_reg < SEL_W'(6));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE:   if (accept) state_next = (s_cmd == CMD_READ) ? ST_RDOUT : ST_DIV;
            ST_DIV:    if (step_reg == STEP_STORE && val_reg == 2'd2) state_next = ST_RD;
            ST_RD:     state_next = ST_WAIT;
            ST_WAIT:   state_next = ST_WR;
            ST_WR:     state_next = (val_reg == 2'd2) ? ST_IDLE : ST_RD;
            ST_RDOUT:  state_next = ST_RDWAIT;
            ST_RDWAIT: state_next = ST_OUT;
            ST_OUT:    if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        m_valid       = (state_reg == ST_OUT);
        rd_addr       = (state_reg == ST_RDOUT) ? rd_sel_addr : rmw_addr;
        wr_addr       = (state_reg == ST_CLEAR) ? clr_reg : rmw_addr;
        wr_total      = (state_reg == ST_CLEAR) || (state_reg == ST_WR);
        wr_gated      = (state_reg == ST_CLEAR) || (state_reg == ST_WR && gate_reg);
        wr_total_data = (state_reg == ST_CLEAR) ? '0 :
                        total_q_reg + COUNT_W'(total_q_reg != '1);
        wr_gated_data = (state_reg == ST_CLEAR) ? '0 :
                        gated_q_reg + COUNT_W'(gated_q_reg != '1);
    end

    assign m_bin_count     = out_reg;
    assign m_overflow_seen = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ovf_reg   <= 1'b0;
            val_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (accept) begin
                trig_reg  <= s_trig_stamp;
                event_reg <= s_event_stamp;
                peak_reg  <= s_peak_value;
                sel_reg   <= s_hist_select;
                binno_reg <= s_bin_number;
                val_reg   <= '0;
                step_reg  <= '0;
                gate_reg  <= (s_trig_stamp > tlo_reg) && (s_trig_stamp < thi_reg) &&
                             (s_event_stamp > elo_reg) && (s_event_stamp < ehi_reg) &&
                             (s_peak_value > plo_reg) && (s_peak_value < phi_reg);
            end
            if (state_reg == ST_DIV) begin
                if (step_reg == 6'd0) begin
                    // load: divide (v-1) by w
                    dvd_reg  <= cur_val - 1'b1;
                    dvs_reg  <= cur_w;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    zero_reg <= (cur_val == '0);
                    wz_reg   <= (cur_w == '0);
                    step_reg <= 6'd1;
                end else if (step_reg == STEP_STORE) begin
                    // quotient final: store bin, move to next value
                    bins_reg[val_reg] <= bin_fin;
                    if (bin_ovf) ovf_reg <= 1'b1;
                    step_reg <= 6'd0;
                    val_reg  <= (val_reg == 2'd2) ? 2'd0 : val_reg + 1'b1;
                end else begin
                    step_reg <= step_reg + 1'b1;
                    dvd_reg  <= {dvd_reg[STAMP_W-2:0], 1'b0};
                    if (rem_ge) begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[STAMP_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[STAMP_W-2:0], 1'b0};
                    end
                end
            end
            if (state_reg == ST_WR) val_reg <= (val_reg == 2'd2) ? 2'd0 : val_reg + 1'b1;
            if (state_reg == ST_RDWAIT) begin
                if (!read_ok) out_reg <= '0;
                else if (sel_reg < SEL_W'(3)) out_reg <= total_q_reg;
                else out_reg <= gated_q_reg;
            end
        end
    end

endmodule

// File: hw/rtl/ghh_checker.sv
module ghh_protocol_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_overflow_seen
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while result pending");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(m_overflow_seen) |-> m_overflow_seen)
        else $error("overflow flag cleared");

    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken on back to back cycles");

endmodule

bind gated_hit_histogrammer_top ghh_protocol_checker u_ghh_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_overflow_seen(m_overflow_seen)
);

// File: test/ghh_checker.sv
module ghh_checker
    import ghh_pkg::*;
#(
    parameter int unsigned NUM_BINS       = 1024,
    parameter int unsigned PEAK_BIN_WIDTH = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [STAMP_W-1:0]   s_trig_stamp,
    input  logic [STAMP_W-1:0]   s_event_stamp,
    input  logic [PEAK_W-1:0]    s_peak_value,
    input  logic [SEL_W-1:0]     s_hist_select,
    input  logic [BIN_IN_W-1:0]  s_bin_number,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [COUNT_W-1:0]   m_bin_count,
    input  logic                 m_overflow_seen,
    output int                   fail_count,
    output int                   reads_pending
);

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic               overflow_seen;
    } read_result_t;

    logic [31:0] trig_width, event_width;
    logic [31:0] trig_lo, trig_hi, event_lo, event_hi;
    logic [23:0] peak_lo, peak_hi;

    logic [COUNT_W-1:0] total_hist [3*NUM_BINS];
    logic [COUNT_W-1:0] gated_hist [3*NUM_BINS];
    logic               overflow_sticky;
    read_result_t       expected_reads[$];

    function automatic int unsigned bin_index(logic [31:0] value, logic [31:0] width);
        logic [32:0] q;
        if (value == 0)
            return 0;
        if (width == 0)
            q = 33'(NUM_BINS);
        else
            q = {1'b0, value - 32'd1} / {1'b0, width} + 33'd1;
        if (q > NUM_BINS - 1) begin
            overflow_sticky = 1'b1;
            q = 33'(NUM_BINS - 1);
        end
        return int'(q);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    always @(posedge aclk) begin
        int unsigned bt, be, bp;
        logic gate;
        int errs;
        read_result_t got, want;
        errs = 0;
        if (!aresetn) begin
            trig_width      <= 32'd5;
            event_width     <= 32'd500;
            trig_lo         <= '0;
            trig_hi         <= 32'd100000;
            event_lo        <= '0;
            event_hi        <= 32'd1000000;
            peak_lo         <= '0;
            peak_hi         <= 24'd10000;
            overflow_sticky = 1'b0;
            for (int i = 0; i < 3*NUM_BINS; i++) begin
                total_hist[i] = '0;
                gated_hist[i] = '0;
            end
            expected_reads.delete();
            fail_count <= 0;
            reads_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_TRIG_BIN_WIDTH:  trig_width  <= cfg_data;
                    REG_EVENT_BIN_WIDTH: event_width <= cfg_data;
                    REG_TRIG_WIN_LOW:    trig_lo     <= cfg_data;
                    REG_TRIG_WIN_HIGH:   trig_hi     <= cfg_data;
                    REG_EVENT_WIN_LOW:   event_lo    <= cfg_data;
                    REG_EVENT_WIN_HIGH:  event_hi    <= cfg_data;
                    REG_PEAK_WIN_LOW:    peak_lo     <= cfg_data[23:0];
                    REG_PEAK_WIN_HIGH:   peak_hi     <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (cmd_t'(s_cmd) == CMD_RECORD) begin
                    bt = bin_index(s_trig_stamp, trig_width);
                    be = bin_index(s_event_stamp, event_width);
                    bp = bin_index({8'd0, s_peak_value}, PEAK_BIN_WIDTH);
                    gate = s_trig_stamp > trig_lo && s_trig_stamp < trig_hi &&
                           s_event_stamp > event_lo && s_event_stamp < event_hi &&
                           s_peak_value > peak_lo && s_peak_value < peak_hi;
                    total_hist[bt]              = sat_inc(total_hist[bt]);
                    total_hist[NUM_BINS+be]     = sat_inc(total_hist[NUM_BINS+be]);
                    total_hist[2*NUM_BINS+bp]   = sat_inc(total_hist[2*NUM_BINS+bp]);
                    if (gate) begin
                        gated_hist[bt]            = sat_inc(gated_hist[bt]);
                        gated_hist[NUM_BINS+be]   = sat_inc(gated_hist[NUM_BINS+be]);
                        gated_hist[2*NUM_BINS+bp] = sat_inc(gated_hist[2*NUM_BINS+bp]);
                    end
                end else begin
                    want.bin_count = '0;
                    if (s_bin_number < NUM_BINS) begin
                        if (s_hist_select < 3)
                            want.bin_count = total_hist[s_hist_select*NUM_BINS + s_bin_number];
                        else if (s_hist_select < 6)
                            want.bin_count =
                                gated_hist[(s_hist_select-3)*NUM_BINS + s_bin_number];
                    end
                    want.overflow_seen = overflow_sticky;
                    expected_reads.push_back(want);
                end
            end
            if (m_valid && m_ready) begin
                got.bin_count     = m_bin_count;
                got.overflow_seen = m_overflow_seen;
                if (expected_reads.size() == 0) begin
                    $error("unexpected read result: bin_count %0d", got.bin_count);
                    errs++;
                end else begin
                    want = expected_reads.pop_front();
                    if (got.bin_count !== want.bin_count) begin
                        $error("bin_count expected %0d actual %0d",
                               want.bin_count, got.bin_count);
                        errs++;
                    end
                    if (got.overflow_seen !== want.overflow_seen) begin
                        $error("overflow_seen expected %0b actual %0b",
                               want.overflow_seen, got.overflow_seen);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            reads_pending <= expected_reads.size();
        end
    end

endmodule

// File: test/gated_hit_histogrammer_top_tb.sv
module gated_hit_histogrammer_top_tb;
    import ghh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN       = 150;

    logic                 aclk, aresetn;
    logic                 cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid, s_ready, s_cmd;
    logic [STAMP_W-1:0]   s_trig_stamp, s_event_stamp;
    logic [PEAK_W-1:0]    s_peak_value;
    logic [SEL_W-1:0]     s_hist_select;
    logic [BIN_IN_W-1:0]  s_bin_number;
    logic                 m_valid, m_ready;
    logic [COUNT_W-1:0]   m_bin_count;
    logic                 m_overflow_seen;
    int                   fail_count, reads_pending;
    int unsigned          cycles = 0;
    int unsigned          send_idle_pct, recv_stall_pct;
    logic [31:0]          regs [8];

    gated_hit_histogrammer_top i_dut (.*);
    ghh_checker i_chk (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("gated_hit_histogrammer_top_tb NOT OK");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic write_regs();
        for (int i = 0; i < 8; i++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_data  <= regs[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        wait (reads_pending == 0);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic send(cmd_t c, logic [31:0] t, logic [31:0] e, logic [23:0] p,
                        logic [2:0] sel, logic [9:0] bin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= c;
        s_trig_stamp  <= t;
        s_event_stamp <= e;
        s_peak_value  <= p;
        s_hist_select <= sel;
        s_bin_number  <= bin;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic read_bin(logic [2:0] sel, logic [9:0] bin);
        send(CMD_READ, $urandom, $urandom, 24'($urandom), sel, bin);
    endtask

    task automatic record(logic [31:0] t, logic [31:0] e, logic [23:0] p);
        send(CMD_RECORD, t, e, p, 3'($urandom), 10'($urandom));
    endtask

    // value near a bin edge, inside the window, on a window edge or anywhere
    function automatic logic [31:0] pick(logic [31:0] width, logic [31:0] lo,
                                         logic [31:0] hi, logic [31:0] mask);
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = width * $urandom_range(1100) + $urandom_range(2) - 1;
            2: v = (hi > lo + 1) ? lo + 1 + ($urandom % (hi - lo - 1)) : lo;
            default: v = $urandom_range(1) ? lo + $urandom_range(1)
                                           : hi - $urandom_range(1);
        endcase
        return v & mask;
    endfunction

    task automatic random_items(int n);
        logic [9:0] bin;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 60) begin
                record(pick(regs[REG_TRIG_BIN_WIDTH], regs[REG_TRIG_WIN_LOW],
                            regs[REG_TRIG_WIN_HIGH], 32'hFFFF_FFFF),
                       pick(regs[REG_EVENT_BIN_WIDTH], regs[REG_EVENT_WIN_LOW],
                            regs[REG_EVENT_WIN_HIGH], 32'hFFFF_FFFF),
                       24'(pick(20, regs[REG_PEAK_WIN_LOW] & 24'hFFFFFF,
                                regs[REG_PEAK_WIN_HIGH] & 24'hFFFFFF, 32'hFF_FFFF)));
            end else begin
                case ($urandom_range(3))
                    0, 1: bin = 10'($urandom_range(40));
                    2:    bin = 10'($urandom);
                    default: bin = 10'd1023;
                endcase
                read_bin(3'($urandom_range(99) < 90 ? $urandom_range(5) : $urandom_range(7)),
                         bin);
            end
        end
    endtask

    task automatic phase(int unsigned idle, int unsigned stall, int n);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        write_regs();
        random_items(n);
        s_valid <= 1'b0;
        settle();
    endtask

    initial begin
        aresetn = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        s_valid = 0; s_cmd = 0; s_trig_stamp = '0; s_event_stamp = '0;
        s_peak_value = '0; s_hist_select = '0; s_bin_number = '0;
        m_ready = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        regs = '{5, 500, 0, 100000, 0, 1000000, 0, 10000};
        repeat (7) @(negedge aclk);
        aresetn = 1;

        write_regs();
        // bin edges, full-scale values, window edges
        record(0, 0, 0);
        record(5, 500, 20);
        record(6, 501, 21);
        record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
        record(5115, 511500, 20460);
        record(5116, 511501, 20461);
        record(100000, 1000000, 10000);
        record(99999, 999999, 9999);
        record(1, 1, 1);
        for (int s = 0; s < 8; s++)
            read_bin(3'(s), (s < 3) ? 10'd1 : 10'd0);
        read_bin(0, 10'd1023);
        read_bin(1, 10'd1023);
        read_bin(2, 10'd1023);
        read_bin(3, 10'd1);
        read_bin(5, 10'd500);
        read_bin(4, 10'd2);
        random_items(230);
        s_valid <= 1'b0;
        settle();

        regs = '{1, 1, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF};
        phase(54, 0, 250);
        regs = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 50000, 100, 32'hFFFF_FFFF, 0,
                 32'hFF_FFFF, 0};
        phase(0, 54, 250);
        // zero trigger and event widths: any nonzero trigger or event value saturates
        regs = '{0, 0, $urandom_range(1000), $urandom_range(200000),
                 $urandom_range(1000), $urandom_range(2000000), $urandom_range(200),
                 $urandom};
        phase(20, 20, 150);
        regs = '{$urandom_range(1, 1000), $urandom_range(1, 100000), $urandom_range(100),
                 $urandom_range(5000, 50000), $urandom_range(100),
                 $urandom_range(10000, 500000), $urandom_range(100),
                 $urandom_range(1000, 20000)};
        phase(0, 0, 347);

        wait (reads_pending == 0);
        repeat (DRAIN) @(posedge aclk);
        if (fail_count == 0)
            $display("gated_hit_histogrammer_top_tb OK");
        else
            $display("gated_hit_histogrammer_top_tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ghh_pkg.sv
hw/rtl/gated_hit_histogrammer_top.sv
hw/rtl/ghh_checker.sv
test/ghh_checker.sv
test/gated_hit_histogrammer_top_tb.sv
